// File: design/pwrfd_pkg.sv
// shared types, codes and constants of the pulse-width remote frame decoder
package pwrfd_pkg;

    localparam int INTERVAL_BITS = 32;
    localparam int TICK_W        = 32;
    localparam int NUM_WINDOWS   = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int BIT_NUM_W     = 7;

    // only the low INTERVAL_BITS of an interval take part in the compares
    localparam logic [TICK_W-1:0] INTERVAL_MASK =
        (INTERVAL_BITS >= TICK_W) ? {TICK_W{1'b1}}
                                  : TICK_W'((64'd1 << INTERVAL_BITS) - 64'd1);

    localparam logic [BIT_NUM_W-1:0] LEN_BASE   = 7'd16;
    localparam logic [BIT_NUM_W-1:0] LEN_PLAYER = 7'd104;
    localparam logic [BIT_NUM_W-1:0] LEN_CEDE   = 7'd115;
    localparam logic [BIT_NUM_W-1:0] BIT_REMOTE = 7'd5;
    localparam logic [BIT_NUM_W-1:0] BIT_PLAYER = 7'd9;
    localparam logic [BIT_NUM_W-1:0] BIT_CEDE   = 7'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_WIN         = 3'd0,
        CFG_PRESYNC_WIN       = 3'd1,
        CFG_PRESYNC_DELAY_WIN = 3'd2,
        CFG_SYNC_WIN          = 3'd3,
        CFG_SHORT_WIN         = 3'd4,
        CFG_LONG_WIN          = 3'd5
    } t_cfg_index;

    typedef enum logic [2:0] {
        EV_RESET         = 3'd0,
        EV_PRESYNC       = 3'd1,
        EV_UNEXPECTED    = 3'd2,
        EV_PRESYNC_DELAY = 3'd3,
        EV_SYNC          = 3'd4,
        EV_ERROR         = 3'd5,
        EV_BIT           = 3'd6
    } t_event;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_PRESYNC  = 5'b00010,
        PH_SYNC     = 5'b00100,
        PH_BIT_HIGH = 5'b01000,
        PH_BIT_LOW  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] hi;   // exclusive maximum
        logic [TICK_W-1:0] lo;   // minimum
    } t_window;

    typedef t_window [NUM_WINDOWS-1:0] t_win_set;

    typedef struct packed {
        logic reset_hit;
        logic presync_hit;
        logic presync_delay_hit;
        logic sync_hit;
        logic short_hit;
        logic long_hit;
    } t_win_hits;

    typedef struct packed {
        logic              level;
        logic [TICK_W-1:0] interval;
    } t_in_item;

    typedef struct packed {
        t_event               event_res;
        logic                 bit_value;
        logic [BIT_NUM_W-1:0] bit_number;
        logic                 message_end;
        logic                 remote_wants_bus;
        logic                 player_has_data;
        logic                 player_cedes;
        logic                 cede_unrequested;
    } t_out_item;

endpackage

// File: design/pwrfd_classify.sv
// half-open window compares of one edge interval against all configured windows
module pwrfd_classify
    import pwrfd_pkg::*;
(
    input  logic [TICK_W-1:0] i_interval,
    input  t_win_set          i_windows,
    output t_win_hits         o_hits
);

    logic [TICK_W-1:0]      t;
    logic [NUM_WINDOWS-1:0] hit;

    assign t = i_interval & INTERVAL_MASK;

    always_comb begin
        for (int k = 0; k < NUM_WINDOWS; k++) begin
            hit[k] = (t >= i_windows[k].lo) && (t < i_windows[k].hi);
        end
    end

    assign o_hits.reset_hit         = hit[CFG_RESET_WIN];
    assign o_hits.presync_hit       = hit[CFG_PRESYNC_WIN];
    assign o_hits.presync_delay_hit = hit[CFG_PRESYNC_DELAY_WIN];
    assign o_hits.sync_hit          = hit[CFG_SYNC_WIN];
    assign o_hits.short_hit         = hit[CFG_SHORT_WIN];
    assign o_hits.long_hit          = hit[CFG_LONG_WIN];

endmodule

// File: design/pulse_width_remote_frame_decoder_core.sv
// top level of the pulse-width remote frame decoder
//
// usage
//   input channel : one transaction per line edge, carrying the level after the
//                   edge and the ticks since the previous edge
//   output channel: zero or one result transaction per edge (events, decoded
//                   bits with their number, message end and the bus flags)
//   config channel: six 64-bit timing windows, index 0..5, min in bits 31..0
//                   and exclusive max in bits 63..32; o_cfg_ready is always high,
//                   writes are to be made only while the block is idle; not enforced
// pipeline
//   an accepted edge waits in the input register, is decoded there and loads
//   its result once the result register is free; one edge per cycle is
//   sustained while the receiver does not stall (single input and result register)
// reset
//   synchronous, active low: all windows read as empty, phase idle, line level
//   taken as low, expected message length sixteen bits, flags clear
// receiver stall
//   a held result keeps its payload; the edge waiting behind it stays in the
//   input register and o_in_stall rises only once that register is also held
module pulse_width_remote_frame_decoder_core
    import pwrfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // edge events
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // decoded results
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    // window registers
    t_win_set r_win;

    // input stage
    logic     r_a_valid;
    t_in_item r_a_data;

    // result stage
    logic      r_out_valid;
    t_out_item r_out_data;

    // decoder state
    t_phase               r_phase,    n_phase;
    logic                 r_prev_lvl;
    logic [BIT_NUM_W-1:0] r_bits_seen, n_bits_seen;
    logic [BIT_NUM_W-1:0] r_bits_exp,  n_bits_exp;
    logic                 r_remote,   n_remote;
    logic                 r_player,   n_player;
    logic                 r_cede,     n_cede;

    logic      res_valid;
    t_out_item res;
    t_win_hits hits;

    logic out_free;
    logic a_advance;
    logic in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_RESET_WIN:         r_win[CFG_RESET_WIN]         <= i_cfg_data;
                CFG_PRESYNC_WIN:       r_win[CFG_PRESYNC_WIN]       <= i_cfg_data;
                CFG_PRESYNC_DELAY_WIN: r_win[CFG_PRESYNC_DELAY_WIN] <= i_cfg_data;
                CFG_SYNC_WIN:          r_win[CFG_SYNC_WIN]          <= i_cfg_data;
                CFG_SHORT_WIN:         r_win[CFG_SHORT_WIN]         <= i_cfg_data;
                CFG_LONG_WIN:          r_win[CFG_LONG_WIN]          <= i_cfg_data;
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // handshake: the input register drains whenever the result register
    // is empty or being emptied this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign a_advance  = r_a_valid && out_free;
    assign o_in_stall = r_a_valid && !a_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_data <= i_in_data;
        end
    end

    pwrfd_classify u_classify (
        .i_interval (r_a_data.interval),
        .i_windows  (r_win),
        .o_hits     (hits)
    );

    // one step of the phase machine for the edge in the input register
    always_comb begin
        logic                 bit_v;
        logic [BIT_NUM_W-1:0] bit_n;
        logic                 msg_end;
        logic                 unreq;

        n_phase     = r_phase;
        n_bits_seen = r_bits_seen;
        n_bits_exp  = r_bits_exp;
        n_remote    = r_remote;
        n_player    = r_player;
        n_cede      = r_cede;
        res_valid   = 1'b0;
        res         = '0;
        bit_v       = 1'b0;
        bit_n       = r_bits_seen + 7'd1;
        msg_end     = 1'b0;
        unreq       = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                // only a rising edge can open a frame
                if (!r_prev_lvl && r_a_data.level) begin
                    if (hits.reset_hit) begin
                        n_phase       = PH_PRESYNC;
                        res_valid     = 1'b1;
                        res.event_res = EV_RESET;
                    end else if (hits.presync_hit) begin
                        n_phase       = PH_PRESYNC;
                        res_valid     = 1'b1;
                        res.event_res = EV_PRESYNC;
                    end else if (hits.short_hit || hits.long_hit) begin
                        res_valid     = 1'b1;
                        res.event_res = EV_UNEXPECTED;
                    end
                end
            end
            PH_PRESYNC: begin
                res_valid = 1'b1;
                if (hits.presync_delay_hit) begin
                    n_phase       = PH_SYNC;
                    res.event_res = EV_PRESYNC_DELAY;
                end else begin
                    n_phase       = PH_IDLE;
                    res.event_res = EV_ERROR;
                end
            end
            PH_SYNC: begin
                res_valid = 1'b1;
                if (hits.sync_hit) begin
                    n_phase       = PH_BIT_HIGH;
                    n_bits_seen   = '0;
                    res.event_res = EV_SYNC;
                end else begin
                    n_phase       = PH_IDLE;
                    res.event_res = EV_ERROR;
                end
            end
            PH_BIT_HIGH: begin
                n_phase = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
                res_valid = 1'b1;
                if (hits.short_hit || hits.long_hit) begin
                    // short low time wins over long when windows overlap
                    bit_v = hits.short_hit;
                    if (bit_n == BIT_REMOTE && bit_v) begin
                        n_remote = 1'b1;
                    end
                    if (bit_n == BIT_PLAYER && !bit_v) begin
                        n_player = 1'b1;
                    end
                    if (bit_n == BIT_CEDE) begin
                        if (bit_v) begin
                            n_cede = 1'b1;
                        end
                        if (n_cede) begin
                            unreq      = !n_remote;
                            n_bits_exp = LEN_CEDE;
                        end else if (n_player) begin
                            n_bits_exp = LEN_PLAYER;
                        end
                    end
                    msg_end = (bit_n == n_bits_exp);

                    res.event_res        = EV_BIT;
                    res.bit_value        = bit_v;
                    res.bit_number       = bit_n;
                    res.message_end      = msg_end;
                    res.remote_wants_bus = n_remote;
                    res.player_has_data  = n_player;
                    res.player_cedes     = n_cede;
                    res.cede_unrequested = unreq;

                    n_bits_seen = bit_n;
                    n_phase     = msg_end ? PH_IDLE : PH_BIT_HIGH;
                end else begin
                    n_phase       = PH_IDLE;
                    res.event_res = EV_ERROR;
                end
            end
            default: begin
                // lost phase code: fall back to idle quietly
                n_phase = PH_IDLE;
            end
        endcase

        // leaving a frame for idle clears the frame state
        if (n_phase == PH_IDLE) begin
            n_bits_seen = '0;
            n_bits_exp  = LEN_BASE;
            n_remote    = 1'b0;
            n_player    = 1'b0;
            n_cede      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_prev_lvl  <= 1'b0;
            r_bits_seen <= '0;
            r_bits_exp  <= LEN_BASE;
            r_remote    <= 1'b0;
            r_player    <= 1'b0;
            r_cede      <= 1'b0;
        end else if (a_advance) begin
            r_phase     <= n_phase;
            r_prev_lvl  <= r_a_data.level;
            r_bits_seen <= n_bits_seen;
            r_bits_exp  <= n_bits_exp;
            r_remote    <= n_remote;
            r_player    <= n_player;
            r_cede      <= n_cede;
        end
    end

    // result register: only loaded when free, so a held result never changes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_advance) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_advance && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: design/pwrfd_checker.sv
// port-level checks of the pulse-width remote frame decoder and their binding
module pwrfd_checker
    import pwrfd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input t_in_item             i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out_data
);

    // a stalled edge waits unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("edge changed while stalled");

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // events other than data bits carry nothing else
    a_event_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res != EV_BIT |->
            !o_out_data.bit_value && o_out_data.bit_number == '0 &&
            !o_out_data.message_end && !o_out_data.remote_wants_bus &&
            !o_out_data.player_has_data && !o_out_data.player_cedes &&
            !o_out_data.cede_unrequested)
        else $error("non-bit event with payload");

    // a message can only end at one of the three frame lengths
    a_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.message_end |->
            o_out_data.bit_number == LEN_BASE ||
            o_out_data.bit_number == LEN_PLAYER ||
            o_out_data.bit_number == LEN_CEDE)
        else $error("message end at unexpected bit count");

    // unrequested cede only flagged on the cede bit itself
    a_unreq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.cede_unrequested |->
            o_out_data.player_cedes && !o_out_data.remote_wants_bus &&
            o_out_data.bit_number == BIT_CEDE)
        else $error("bad unrequested cede");

endmodule

bind pulse_width_remote_frame_decoder_core pwrfd_checker u_pwrfd_checker (.*);

// File: tb/pwrfd_checker.sv
// watches the channels of the remote frame decoder, predicts its results and compares them
`timescale 1ns / 1ps

module pwrfd_tb_checker
    import pwrfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);

    t_win_set             windows;
    t_phase               phase;
    logic                 prev_level;
    logic [BIT_NUM_W-1:0] bits_seen;
    logic [BIT_NUM_W-1:0] bits_expected;
    logic                 remote_flag;
    logic                 player_flag;
    logic                 cede_flag;
    t_out_item            decoded_q[$];
    int                   mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic hit(input logic [TICK_W-1:0] t, input t_window w);
        return (t >= w.lo) && (t < w.hi);
    endfunction

    function automatic void back_to_idle();
        phase         = PH_IDLE;
        bits_seen     = '0;
        bits_expected = LEN_BASE;
        remote_flag   = 1'b0;
        player_flag   = 1'b0;
        cede_flag     = 1'b0;
    endfunction

    // one line edge through the phase machine; returns 1 when it yields a result
    function automatic logic decode_edge(input t_in_item e, output t_out_item r);
        logic [TICK_W-1:0] t;
        logic              was_low;
        logic              bit_v;
        t          = e.interval & INTERVAL_MASK;
        was_low    = ~prev_level;
        prev_level = e.level;
        r          = '0;
        case (phase)
            PH_IDLE: begin
                if (was_low && e.level) begin
                    if (hit(t, windows[CFG_RESET_WIN])) begin
                        phase       = PH_PRESYNC;
                        r.event_res = EV_RESET;
                        return 1'b1;
                    end
                    if (hit(t, windows[CFG_PRESYNC_WIN])) begin
                        phase       = PH_PRESYNC;
                        r.event_res = EV_PRESYNC;
                        return 1'b1;
                    end
                    if (hit(t, windows[CFG_SHORT_WIN]) || hit(t, windows[CFG_LONG_WIN])) begin
                        r.event_res = EV_UNEXPECTED;
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            PH_PRESYNC: begin
                if (hit(t, windows[CFG_PRESYNC_DELAY_WIN])) begin
                    phase       = PH_SYNC;
                    r.event_res = EV_PRESYNC_DELAY;
                end else begin
                    back_to_idle();
                    r.event_res = EV_ERROR;
                end
                return 1'b1;
            end
            PH_SYNC: begin
                if (hit(t, windows[CFG_SYNC_WIN])) begin
                    bits_seen   = '0;
                    phase       = PH_BIT_HIGH;
                    r.event_res = EV_SYNC;
                end else begin
                    back_to_idle();
                    r.event_res = EV_ERROR;
                end
                return 1'b1;
            end
            PH_BIT_HIGH: begin
                phase = PH_BIT_LOW;
                return 1'b0;
            end
            PH_BIT_LOW: begin
                // short tested before long
                if (hit(t, windows[CFG_SHORT_WIN])) begin
                    bit_v = 1'b1;
                end else if (hit(t, windows[CFG_LONG_WIN])) begin
                    bit_v = 1'b0;
                end else begin
                    back_to_idle();
                    r.event_res = EV_ERROR;
                    return 1'b1;
                end
                bits_seen = bits_seen + 7'd1;
                if (bits_seen == BIT_REMOTE && bit_v)
                    remote_flag = 1'b1;
                if (bits_seen == BIT_PLAYER && !bit_v)
                    player_flag = 1'b1;
                if (bits_seen == BIT_CEDE) begin
                    if (bit_v)
                        cede_flag = 1'b1;
                    if (cede_flag) begin
                        r.cede_unrequested = ~remote_flag;
                        bits_expected      = LEN_CEDE;
                    end else if (player_flag) begin
                        bits_expected = LEN_PLAYER;
                    end
                end
                r.event_res        = EV_BIT;
                r.bit_value        = bit_v;
                r.bit_number       = bits_seen;
                r.message_end      = (bits_seen == bits_expected);
                r.remote_wants_bus = remote_flag;
                r.player_has_data  = player_flag;
                r.player_cedes     = cede_flag;
                if (r.message_end)
                    back_to_idle();
                else
                    phase = PH_BIT_HIGH;
                return 1'b1;
            end
            default: begin
                back_to_idle();
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            windows    = '0;
            prev_level = 1'b0;
            back_to_idle();
            decoded_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_WINDOWS)
                windows[i_cfg_index] = i_cfg_data;
            // results leave before the same-edge input is decoded
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (decoded_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with none expected, event %0d", $time,
                                 got.event_res);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(got.event_res));
                    check_field("bit_value", 32'(want.bit_value), 32'(got.bit_value));
                    check_field("bit_number", 32'(want.bit_number), 32'(got.bit_number));
                    check_field("message_end", 32'(want.message_end),
                                32'(got.message_end));
                    check_field("remote_wants_bus", 32'(want.remote_wants_bus),
                                32'(got.remote_wants_bus));
                    check_field("player_has_data", 32'(want.player_has_data),
                                32'(got.player_has_data));
                    check_field("player_cedes", 32'(want.player_cedes),
                                32'(got.player_cedes));
                    check_field("cede_unrequested", 32'(want.cede_unrequested),
                                32'(got.cede_unrequested));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (decode_edge(i_in_data, want))
                    decoded_q.push_back(want);
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

// File: tb/testbench.sv
// stimulus and verdict for the pulse-width remote frame decoder
`timescale 1ns / 1ps

module testbench;
    import pwrfd_pkg::*;

    localparam int HOLD_CYCLES    = 200;   // one long receiver hold-off
    localparam int SETTLE_CYCLES  = 4;     // input and result register plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int unsigned ITEM_TARGET = 1100;  // last run tops up towards this

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    int                   pending;
    int                   fail_count;

    // stimulus side bookkeeping
    t_win_set    cur_windows;
    logic        drv_level = 1'b0;   // level of the last edge sent
    logic        offering = 1'b0;    // shadow of in_valid, set in the same step
    int unsigned send_calm = 0;
    int unsigned items_sent = 0;
    int unsigned holds_asked = 0;
    int unsigned idle_cycles = 0;

    always #2 clk = ~clk;

    pulse_width_remote_frame_decoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pwrfd_tb_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // idle length for either side: mostly none or short, a few long,
    // and now and then a calm stretch with no idling at all
    function automatic int unsigned idle_len(inout int unsigned calm_left);
        int unsigned r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_window window(input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] hi);
        t_window w;
        w.lo = lo;
        w.hi = hi;
        return w;
    endfunction

    // interval inside a window, boundaries now and then; anything if it is empty
    function automatic logic [TICK_W-1:0] pick_in(input t_window w);
        int unsigned r;
        if (w.lo >= w.hi)
            return $urandom;
        r = $urandom_range(0, 9);
        if (r == 0)
            return w.lo;
        if (r == 1)
            return w.hi - 32'd1;
        return w.lo + ($urandom % (w.hi - w.lo));
    endfunction

    // interval meant to miss a window: just outside it, the extremes or noise
    function automatic logic [TICK_W-1:0] near_miss(input t_window w);
        case ($urandom_range(0, 4))
            0:       return w.hi;
            1:       return w.lo - 32'd1;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_win_set random_windows();
        t_win_set    s;
        logic [31:0] lo;
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            lo = $urandom_range(0, 2000);
            // an inverted window reads as empty
            if ($urandom_range(0, 9) == 0)
                s[i] = window(lo, $urandom_range(0, lo));
            else
                s[i] = window(lo, lo + $urandom_range(1, 400));
        end
        return s;
    endfunction

    // watchdog: too long without any transaction on any channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off whenever one is asked for
    initial begin : receiver
        int unsigned stall_len;
        int unsigned holds_served;
        int unsigned calm;
        holds_served = 0;
        calm         = 0;
        wait (rst_n);
        forever begin
            if (holds_asked != holds_served) begin
                holds_served++;
                stall_len = HOLD_CYCLES;
            end else begin
                stall_len = idle_len(calm);
            end
            if (stall_len > 0) begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

    // one edge transaction; valid stays high when no gap follows
    task automatic send_edge(input logic level, input logic [TICK_W-1:0] interval);
        t_in_item    e;
        int unsigned gap;
        e.level    = level;
        e.interval = interval;
        in_valid  <= 1'b1;
        in_data   <= e;
        offering   = 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
        drv_level = level;
        gap = idle_len(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            offering  = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every predicted result has come out
    task automatic drain_results();
        if (offering) begin
            in_valid <= 1'b0;
            offering  = 1'b0;
        end
        // pending is registered, so it lags the queue
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // edges that yield nothing may still sit in the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // reprogram all six windows while the decoder is idle
    task automatic load_windows(input t_win_set s);
        drain_results();
        write_reg(CFG_RESET_WIN, s[CFG_RESET_WIN]);
        write_reg(CFG_PRESYNC_WIN, s[CFG_PRESYNC_WIN]);
        write_reg(CFG_PRESYNC_DELAY_WIN, s[CFG_PRESYNC_DELAY_WIN]);
        write_reg(CFG_SYNC_WIN, s[CFG_SYNC_WIN]);
        write_reg(CFG_SHORT_WIN, s[CFG_SHORT_WIN]);
        write_reg(CFG_LONG_WIN, s[CFG_LONG_WIN]);
        cfg_valid <= 1'b0;
        cur_windows = s;
    endtask

    // frame edge aimed at a window; the level is occasionally flipped,
    // which only matters while idle
    task automatic frame_edge(input logic level, input t_window w, input logic spoiled);
        logic lvl;
        lvl = level ^ ($urandom_range(0, 19) == 0);
        send_edge(lvl, spoiled ? near_miss(w) : pick_in(w));
    endtask

    // a whole message: lead pulse, presync delay, sync and the data bits,
    // the flag bits choosing 16, 104 or 115 bits; some frames are broken
    // at a random edge and abandoned there
    task automatic send_frame();
        logic        remote_bit;
        logic        player;
        logic        cede;
        logic        bit_v;
        int unsigned len;
        int unsigned spoil;
        remote_bit = $urandom_range(0, 1);
        cede       = ($urandom_range(0, 99) < 15);
        player     = ($urandom_range(0, 99) < 20);
        len        = cede ? 115 : (player ? 104 : 16);
        spoil      = ($urandom_range(0, 99) < 20) ? $urandom_range(1, len + 3) : 0;
        // the line must be low before the rising edge that ends the lead pulse
        if (drv_level)
            send_edge(1'b0, $urandom_range(0, 2000));
        frame_edge(1'b1, $urandom_range(0, 1) ? cur_windows[CFG_RESET_WIN]
                                               : cur_windows[CFG_PRESYNC_WIN], spoil == 1);
        if (spoil == 1)
            return;
        frame_edge(1'b0, cur_windows[CFG_PRESYNC_DELAY_WIN], spoil == 2);
        if (spoil == 2)
            return;
        frame_edge(1'b1, cur_windows[CFG_SYNC_WIN], spoil == 3);
        if (spoil == 3)
            return;
        for (int b = 1; b <= len; b++) begin
            if (b == BIT_REMOTE)
                bit_v = remote_bit;
            else if (b == BIT_PLAYER)
                bit_v = ~player;
            else if (b == BIT_CEDE)
                bit_v = cede;
            else
                bit_v = $urandom_range(0, 1);
            // high time is never classified
            send_edge(1'b0, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100));
            frame_edge(1'b1, bit_v ? cur_windows[CFG_SHORT_WIN] : cur_windows[CFG_LONG_WIN],
                       spoil == b + 3);
            if (spoil == b + 3)
                return;
        end
    endtask

    // mostly well-formed frames, the rest loose edges with random content;
    // the frame in progress is finished, so a run overshoots its count
    task automatic run_random(input int unsigned count);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 99) < 12)
                send_edge($urandom_range(0, 1),
                          $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1500));
            else
                send_frame();
        end
    endtask

    initial begin : stimulus
        t_win_set typical;
        t_win_set extremes;
        t_win_set overlapping;

        typical[CFG_RESET_WIN]         = window(1000, 1200);
        typical[CFG_PRESYNC_WIN]       = window(500, 700);
        typical[CFG_PRESYNC_DELAY_WIN] = window(200, 400);
        typical[CFG_SYNC_WIN]          = window(100, 200);
        typical[CFG_SHORT_WIN]         = window(20, 40);
        typical[CFG_LONG_WIN]          = window(50, 80);

        // single-point, near-maximum and full-range windows; short takes the
        // lower half so long only wins above it, the all-ones interval misses
        extremes[CFG_RESET_WIN]         = window(32'd0, 32'd1);
        extremes[CFG_PRESYNC_WIN]       = window(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        extremes[CFG_PRESYNC_DELAY_WIN] = window(32'd0, 32'hFFFF_FFFF);
        extremes[CFG_SYNC_WIN]          = window(32'h8000_0000, 32'hFFFF_FFFF);
        extremes[CFG_SHORT_WIN]         = window(32'd0, 32'h8000_0000);
        extremes[CFG_LONG_WIN]          = window(32'd0, 32'hFFFF_FFFF);

        // all-ones register leaves reset empty; neighbouring windows overlap
        overlapping[CFG_RESET_WIN]         = '1;
        overlapping[CFG_PRESYNC_WIN]       = window(500, 700);
        overlapping[CFG_PRESYNC_DELAY_WIN] = window(150, 450);
        overlapping[CFG_SYNC_WIN]          = window(100, 300);
        overlapping[CFG_SHORT_WIN]         = window(30, 60);
        overlapping[CFG_LONG_WIN]          = window(40, 90);

        cur_windows = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // windows still empty after reset: rising edges find nothing
        send_edge(1'b1, 32'd0);
        send_edge(1'b0, 32'd500);
        send_edge(1'b1, 32'hFFFF_FFFF);

        load_windows(typical);
        // directed: idle cases, each event, window boundaries, errors per phase
        send_edge(1'b0, 32'd1100);        // falling edge while idle, ignored
        send_edge(1'b1, 32'd0);           // rising, in no window
        send_edge(1'b0, 32'hFFFF_FFFF);
        send_edge(1'b1, 32'd30);          // data bit while idle, short
        send_edge(1'b0, 32'd5);
        send_edge(1'b1, 32'd60);          // data bit while idle, long
        send_edge(1'b0, 32'd5);
        send_edge(1'b1, 32'd1000);        // reset pulse at its minimum
        send_edge(1'b0, 32'd399);         // presync delay just below its maximum
        send_edge(1'b1, 32'd100);         // sync at its minimum
        send_edge(1'b0, 32'd7);
        send_edge(1'b1, 32'd20);          // first bit, one
        send_edge(1'b0, 32'd7);
        send_edge(1'b1, 32'd79);          // second bit, zero
        send_edge(1'b0, 32'd7);
        send_edge(1'b1, 32'd40);          // short maximum is exclusive: timing error
        send_edge(1'b0, 32'd1);
        send_edge(1'b1, 32'd1200);        // reset maximum is exclusive: nothing
        send_edge(1'b0, 32'd1);
        send_edge(1'b1, 32'd500);         // presync pulse
        send_edge(1'b0, 32'd400);         // presync delay too long: timing error
        send_edge(1'b1, 32'd650);         // presync again
        send_edge(1'b0, 32'd300);
        send_edge(1'b0, 32'd99);          // level ignored, sync too short: error
        send_edge(1'b1, 32'hFFFF_FFFF);   // saturated interval while idle

        run_random(80);
        // receiver holds off while frames keep coming, so the decoder backs up
        holds_asked <= holds_asked + 1;
        run_random(60);
        drain_results();
        run_random(50);

        load_windows(extremes);
        run_random(60);
        load_windows(overlapping);
        run_random(80);
        load_windows(random_windows());
        run_random(60);
        load_windows(typical);
        holds_asked <= holds_asked + 1;
        // the last run tops the total up to about the target
        run_random((items_sent < ITEM_TARGET) ? ITEM_TARGET - items_sent : 0);

        drain_results();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
